// File: rtl/mi4_pkg.sv
// Shared types, widths and helpers for the 4x4 fixed-point matrix inverse.
// Used by every module under rtl; no dependencies.
`default_nettype none

package mi4_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EW            = 32;
  localparam int IDX_W         = 4;
  localparam int LIMB_W        = 32;
  localparam int N_LIMBS       = 4;
  localparam int BW            = N_LIMBS * LIMB_W;
  localparam int ADJ_W         = 100;
  localparam int ACC_W         = 136;
  localparam int PROD_W        = 2 * LIMB_W + 2;

  localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

  localparam logic [1:0] LIMB_ONE   = 2'd0;
  localparam logic [1:0] LIMB_MINOR = 2'd2;
  localparam logic [1:0] LIMB_ADJ   = 2'd3;
  localparam logic [1:0] K_LAST     = 2'd2;
  localparam logic [1:0] ROW_LAST   = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  element_index;
    logic signed [31:0] element_value;
  } mi4_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_index;
    logic signed [31:0] out_value;
    logic              singular;
    logic              last_element;
  } mi4_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_LD_B,
    ST_MAC_WAIT,
    ST_ADJ_WR,
    ST_DET_WR,
    ST_Q_RD,
    ST_Q_START,
    ST_Q_WAIT,
    ST_EMIT
  } mi4_state_t;

  typedef enum logic [1:0] {
    TM_POS,
    TM_NEG,
    TM_COF
  } mi4_term_t;

  typedef enum logic [1:0] {
    B_ELEM,
    B_ACC0,
    B_ADJ
  } mi4_bsrc_t;

  typedef struct packed {
    logic             elem_we;
    logic             elem_rd;
    logic [IDX_W-1:0] elem_addr;
    logic             adj_rd;
    logic             adj_wr;
    logic [IDX_W-1:0] adj_addr;
    logic             load_a;
    logic             load_b;
    mi4_bsrc_t        b_src;
    logic             mac_start;
    logic             mac_clr;
    logic [1:0]       mac_last;
    logic             mac_sub;
    logic             mac_sel;
    logic             det_wr;
    logic             div_start;
    logic             out_load;
    logic [IDX_W-1:0] out_index;
  } mi4_cmd_t;

  typedef struct packed {
    logic mac_done;
    logic div_done;
    logic det_zero;
    logic out_free;
  } mi4_stat_t;

  function automatic logic [1:0] mi4_skip(input logic [1:0] gap, input logic [1:0] n);
    return (n < gap) ? n : n + 2'd1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mi4_div.sv
// Bit-serial rounding divider: adjugate entry over determinant, saturated to Q format.
// Depends on mi4_pkg.
`default_nettype none

module mi4_div #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [mi4_pkg::ADJ_W-1:0] adj,
  input  logic [mi4_pkg::ACC_W-1:0]       det_mag,
  input  logic                            det_neg,
  output logic                            done,
  output logic [mi4_pkg::EW-1:0]          quot
);
  import mi4_pkg::*;

  localparam int SH      = 2 * FRAC_BITS + 1;
  localparam int NUM_W   = ADJ_W + SH + 1;
  localparam int DEN_W   = ACC_W + EW + 2;
  localparam int DIV_W   = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int CNT_W   = $clog2(EW + 3);
  localparam logic [CNT_W-1:0] CNT_ADD = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_OVF = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FIN = CNT_W'(EW + 2);
  localparam logic [EW-1:0] LIM  = {1'b1, {(EW-1){1'b0}}};
  localparam logic [EW-1:0] MAXP = {1'b0, {(EW-1){1'b1}}};

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [EW-1:0]    q;
  logic             ovf;
  logic             neg;
  logic [ADJ_W-1:0] adj_mag;
  logic             ge;
  logic [EW-1:0]    result;

  assign adj_mag = adj[ADJ_W-1] ? ADJ_W'(-adj) : adj;
  assign ge      = rem >= dsh;

  always_comb begin
    if (neg) begin
      result = (ovf || q > LIM) ? LIM : (~q + 1'b1);
    end else begin
      result = (ovf || q > MAXP) ? MAXP : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_FIN) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DIV_W'(adj_mag) << SH;
      dsh <= DIV_W'(det_mag) << EW;
      neg <= adj[ADJ_W-1] ^ det_neg;
    end else if (busy) begin
      priority if (cnt == CNT_ADD) begin
        rem <= rem + DIV_W'(det_mag);
      end else if (cnt == CNT_OVF) begin
        ovf <= rem >= (dsh << 1);
      end else if (cnt == CNT_FIN) begin
        quot <= result;
      end else begin
        if (ge) begin
          rem <= rem - dsh;
        end
        q   <= {q[EW-2:0], ge};
        dsh <= dsh >> 1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mi4_dp.sv
// Datapath: element and adjugate stores, limb-serial multiply-accumulate, determinant,
// divider and result register. Depends on mi4_pkg and mi4_div.
`default_nettype none

module mi4_dp #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mi4_pkg::mi4_in_t   element,
  input  mi4_pkg::mi4_cmd_t  cmd,
  output mi4_pkg::mi4_stat_t stat,
  input  logic               inverse_stall,
  output logic               inverse_valid,
  output mi4_pkg::mi4_out_t  inverse
);
  import mi4_pkg::*;

  localparam int LIMB_SH = $clog2(LIMB_W);
  localparam logic [EW-1:0] ONE_VAL = EW'(1) << FRAC_BITS;

  logic [EW-1:0]    elem_mem [16];
  logic [ADJ_W-1:0] adj_mem [16];
  logic signed [EW-1:0]    erd;
  logic signed [ADJ_W-1:0] adj_rd;

  logic signed [EW-1:0]                a_reg;
  logic [N_LIMBS-1:0][LIMB_W-1:0]      b_reg;

  logic       mi_act;
  logic [1:0] mi_k;
  logic [1:0] mi_last;
  logic       mi_sub;
  logic       mi_sel;
  logic signed [LIMB_W:0] a_op;
  logic signed [LIMB_W:0] limb_op;

  logic signed [PROD_W-1:0] prod;
  logic       p_valid;
  logic [1:0] p_k;
  logic       p_last;
  logic       p_sub;
  logic       p_sel;
  logic [LIMB_SH+1:0]       shamt;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  acc_cur;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [ACC_W-1:0]  acc0;
  logic signed [ACC_W-1:0]  acc1;

  logic [ACC_W-1:0] det_mag;
  logic             det_neg;
  logic             det_zero;
  logic             div_done;
  logic [EW-1:0]    quot;
  logic             diag;

  always_ff @(posedge clk) begin
    if (cmd.elem_we) begin
      elem_mem[element.element_index] <= element.element_value;
    end
    if (cmd.elem_rd) begin
      erd <= elem_mem[cmd.elem_addr];
    end
    if (cmd.adj_wr) begin
      adj_mem[cmd.adj_addr] <= acc1[ADJ_W-1:0];
    end
    if (cmd.adj_rd) begin
      adj_rd <= adj_mem[cmd.adj_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_reg <= erd;
    end
    if (cmd.load_b) begin
      unique case (cmd.b_src)
        B_ELEM:  b_reg <= {{(BW-EW){erd[EW-1]}}, erd};
        B_ACC0:  b_reg <= acc0[BW-1:0];
        B_ADJ:   b_reg <= {{(BW-ADJ_W){adj_rd[ADJ_W-1]}}, adj_rd};
        default: b_reg <= b_reg;
      endcase
    end
  end

  assign a_op    = {a_reg[EW-1], a_reg};
  assign limb_op = (mi_k == mi_last) ? {b_reg[mi_k][LIMB_W-1], b_reg[mi_k]}
                                     : {1'b0, b_reg[mi_k]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mi_act  <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= mi_act;
      if (cmd.mac_start) begin
        mi_act <= 1'b1;
      end else if (mi_act && mi_k == mi_last) begin
        mi_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      mi_k    <= '0;
      mi_last <= cmd.mac_last;
      mi_sub  <= cmd.mac_sub;
      mi_sel  <= cmd.mac_sel;
    end else if (mi_act) begin
      mi_k <= mi_k + 1'b1;
    end
    prod   <= a_op * limb_op;
    p_k    <= mi_k;
    p_last <= mi_k == mi_last;
    p_sub  <= mi_sub;
    p_sel  <= mi_sel;
  end

  assign shamt   = {p_k, {LIMB_SH{1'b0}}};
  assign shifted = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} << shamt;
  assign acc_cur = p_sel ? acc1 : acc0;
  assign acc_new = p_sub ? acc_cur - shifted : acc_cur + shifted;

  always_ff @(posedge clk) begin
    priority if (cmd.mac_start && cmd.mac_clr) begin
      if (cmd.mac_sel) begin
        acc1 <= '0;
      end else begin
        acc0 <= '0;
      end
    end else if (p_valid) begin
      if (p_sel) begin
        acc1 <= acc_new;
      end else begin
        acc0 <= acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.det_wr) begin
      det_neg  <= acc1[ACC_W-1];
      det_mag  <= acc1[ACC_W-1] ? ACC_W'(-acc1) : acc1;
      det_zero <= acc1 == '0;
    end
  end

  mi4_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .adj    (adj_rd),
    .det_mag(det_mag),
    .det_neg(det_neg),
    .done   (div_done),
    .quot   (quot)
  );

  assign diag = cmd.out_index[3:2] == cmd.out_index[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_valid <= 1'b0;
    end else if (cmd.out_load) begin
      inverse_valid <= 1'b1;
    end else if (!inverse_stall) begin
      inverse_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      inverse.out_index    <= cmd.out_index;
      inverse.out_value    <= det_zero ? (diag ? ONE_VAL : '0) : quot;
      inverse.singular     <= det_zero;
      inverse.last_element <= cmd.out_index == LAST_IDX;
    end
  end

  assign stat.mac_done = p_valid && p_last;
  assign stat.div_done = div_done;
  assign stat.det_zero = det_zero;
  assign stat.out_free = !inverse_valid || !inverse_stall;

endmodule

`default_nettype wire

// File: rtl/mi4_ctrl.sv
// Sequencer: walks cofactor terms, determinant terms and result words, issuing
// datapath commands. Depends on mi4_pkg.
`default_nettype none

module mi4_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        element_valid,
  input  logic [mi4_pkg::IDX_W-1:0]   element_index,
  input  mi4_pkg::mi4_stat_t          stat,
  output mi4_pkg::mi4_cmd_t           cmd,
  output logic                        element_stall
);
  import mi4_pkg::*;

  mi4_state_t       state, state_next;
  logic [IDX_W-1:0] ent, ent_next;
  logic [1:0]       kk, kk_next;
  mi4_term_t        tt, tt_next;
  logic             det_ph, det_ph_next;

  logic [1:0] row, col, kp1, kp2;
  logic [1:0] r0, r1, r2, ck, c1, c2;
  logic [IDX_W-1:0] addr_a, addr_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ent    <= '0;
      kk     <= '0;
      tt     <= TM_POS;
      det_ph <= 1'b0;
    end else begin
      state  <= state_next;
      ent    <= ent_next;
      kk     <= kk_next;
      tt     <= tt_next;
      det_ph <= det_ph_next;
    end
  end

  assign row = ent[3:2];
  assign col = ent[1:0];
  assign kp1 = (kk == K_LAST) ? 2'd0 : kk + 2'd1;
  assign kp2 = (kk == 2'd0) ? K_LAST : kk - 2'd1;
  assign r0  = mi4_skip(col, 2'd0);
  assign r1  = mi4_skip(col, 2'd1);
  assign r2  = mi4_skip(col, 2'd2);
  assign ck  = mi4_skip(row, kk);
  assign c1  = mi4_skip(row, kp1);
  assign c2  = mi4_skip(row, kp2);

  always_comb begin
    unique case (tt)
      TM_POS: begin
        addr_a = {r1, c1};
        addr_b = {r2, c2};
      end
      TM_NEG: begin
        addr_a = {r1, c2};
        addr_b = {r2, c1};
      end
      default: begin
        addr_a = {r0, ck};
        addr_b = {r2, c1};
      end
    endcase
  end

  always_comb begin
    state_next  = state;
    ent_next    = ent;
    kk_next     = kk;
    tt_next     = tt;
    det_ph_next = det_ph;
    unique case (state)
      ST_IDLE: begin
        if (element_valid && element_index == LAST_IDX) begin
          state_next  = ST_RD_A;
          ent_next    = '0;
          kk_next     = '0;
          tt_next     = TM_POS;
          det_ph_next = 1'b0;
        end
      end
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_LD_B;
      ST_LD_B: state_next = ST_MAC_WAIT;
      ST_MAC_WAIT: begin
        if (stat.mac_done) begin
          if (det_ph) begin
            if (ent[1:0] == ROW_LAST) begin
              state_next = ST_DET_WR;
            end else begin
              ent_next   = ent + 1'b1;
              state_next = ST_RD_A;
            end
          end else begin
            unique case (tt)
              TM_POS: begin
                tt_next    = TM_NEG;
                state_next = ST_RD_A;
              end
              TM_NEG: begin
                tt_next    = TM_COF;
                state_next = ST_RD_A;
              end
              default: begin
                tt_next = TM_POS;
                if (kk == K_LAST) begin
                  state_next = ST_ADJ_WR;
                end else begin
                  kk_next    = kk + 2'd1;
                  state_next = ST_RD_A;
                end
              end
            endcase
          end
        end
      end
      ST_ADJ_WR: begin
        kk_next    = '0;
        state_next = ST_RD_A;
        if (ent == LAST_IDX) begin
          ent_next    = '0;
          det_ph_next = 1'b1;
        end else begin
          ent_next = ent + 1'b1;
        end
      end
      ST_DET_WR: begin
        ent_next   = '0;
        state_next = ST_Q_RD;
      end
      ST_Q_RD:    state_next = ST_Q_START;
      ST_Q_START: state_next = stat.det_zero ? ST_EMIT : ST_Q_WAIT;
      ST_Q_WAIT: begin
        if (stat.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          if (ent == LAST_IDX) begin
            state_next = ST_IDLE;
          end else begin
            ent_next   = ent + 1'b1;
            state_next = ST_Q_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.out_index = ent;
    element_stall = state != ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        cmd.elem_we = element_valid;
      end
      ST_RD_A: begin
        cmd.elem_rd  = 1'b1;
        cmd.elem_addr = det_ph ? {2'b00, ent[1:0]} : addr_a;
        cmd.adj_rd   = det_ph;
        cmd.adj_addr = {ent[1:0], 2'b00};
      end
      ST_RD_B: begin
        cmd.load_a    = 1'b1;
        cmd.elem_rd   = !det_ph && tt != TM_COF;
        cmd.elem_addr = addr_b;
      end
      ST_LD_B: begin
        cmd.load_b    = 1'b1;
        cmd.mac_start = 1'b1;
        if (det_ph) begin
          cmd.b_src    = B_ADJ;
          cmd.mac_last = LIMB_ADJ;
          cmd.mac_sub  = 1'b0;
          cmd.mac_sel  = 1'b1;
          cmd.mac_clr  = ent[1:0] == 2'd0;
        end else if (tt == TM_COF) begin
          cmd.b_src    = B_ACC0;
          cmd.mac_last = LIMB_MINOR;
          cmd.mac_sub  = row[0] ^ col[0];
          cmd.mac_sel  = 1'b1;
          cmd.mac_clr  = kk == 2'd0;
        end else begin
          cmd.b_src    = B_ELEM;
          cmd.mac_last = LIMB_ONE;
          cmd.mac_sub  = tt == TM_NEG;
          cmd.mac_sel  = 1'b0;
          cmd.mac_clr  = tt == TM_POS;
        end
      end
      ST_ADJ_WR: begin
        cmd.adj_wr   = 1'b1;
        cmd.adj_addr = ent;
      end
      ST_DET_WR: begin
        cmd.det_wr = 1'b1;
      end
      ST_Q_RD: begin
        cmd.adj_rd   = 1'b1;
        cmd.adj_addr = ent;
      end
      ST_Q_START: begin
        cmd.div_start = !stat.det_zero;
      end
      ST_EMIT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.elem_we = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/matrix_inverse_4x4.sv
// Top level of the 4x4 fixed-point matrix inverse: sequencer plus datapath.
// Depends on mi4_pkg, mi4_ctrl, mi4_dp.
//
//   channel   words in          handshake                  payload
//   element   16 per matrix     element_valid / _stall     mi4_in_t
//   inverse   16 per matrix     inverse_valid / _stall     mi4_out_t
//
// Elements are loaded one per cycle while element_stall is low. After the element at
// index 15 the block computes adjugate and determinant on one 33x33 multiplier used
// limb by limb, then divides out each result word in the one-bit-per-cycle divider.
// A singular matrix skips the divider. element_stall stays high after the word at
// index 15 is accepted until the last result is loaded. inverse_stall holds the result
// register and the sequencer. Reset is synchronous and clears control state only.
`default_nettype none

module matrix_inverse_4x4 #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              element_valid,
  output logic              element_stall,
  input  mi4_pkg::mi4_in_t  element,
  output logic              inverse_valid,
  input  logic              inverse_stall,
  output mi4_pkg::mi4_out_t inverse
);
  import mi4_pkg::*;

  mi4_cmd_t  cmd;
  mi4_stat_t stat;

  mi4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .element_valid(element_valid),
    .element_index(element.element_index),
    .stat         (stat),
    .cmd          (cmd),
    .element_stall(element_stall)
  );

  mi4_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .element      (element),
    .cmd          (cmd),
    .stat         (stat),
    .inverse_stall(inverse_stall),
    .inverse_valid(inverse_valid),
    .inverse      (inverse)
  );

endmodule

`default_nettype wire

// File: rtl/mi4_chk.sv
// Port-level checks for matrix_inverse_4x4, bound to the top level.
// Depends on mi4_pkg.
`default_nettype none

module mi4_chk #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              element_valid,
  input logic              element_stall,
  input mi4_pkg::mi4_in_t  element,
  input logic              inverse_valid,
  input logic              inverse_stall,
  input mi4_pkg::mi4_out_t inverse
);
  import mi4_pkg::*;

  localparam logic [EW-1:0] ONE_VAL = EW'(1) << FRAC_BITS;

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    element_valid && !element_stall && element.element_index == LAST_IDX
    |=> element_stall)
    else $error("accepted a word right after the closing element");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    inverse_valid && inverse_stall |=> inverse_valid && $stable(inverse))
    else $error("stalled result word changed");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    inverse_valid |-> inverse.last_element == (inverse.out_index == LAST_IDX))
    else $error("last flag out of place");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    inverse_valid && inverse.singular |->
      inverse.out_value == ((inverse.out_index[3:2] == inverse.out_index[1:0]) ?
                            ONE_VAL : '0))
    else $error("singular result is not identity");

endmodule

bind matrix_inverse_4x4 mi4_chk #(
  .FRAC_BITS(FRAC_BITS)
) u_mi4_chk (
  .clk          (clk),
  .rst          (rst),
  .element_valid(element_valid),
  .element_stall(element_stall),
  .element      (element),
  .inverse_valid(inverse_valid),
  .inverse_stall(inverse_stall),
  .inverse      (inverse)
);

`default_nettype wire
